// ===== src/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types, widths and constant tables for the dimmed hsv to rgb565 block.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // fraction bits of the unsigned fixed point values
    localparam int FRAC_BITS = 16;

    // fraction word, wide enough to hold exactly one
    localparam int FRAC_W = FRAC_BITS + 1;
    typedef logic [FRAC_W-1:0] frac_t;

    // dimming denominator ray_length + 1 and the numerator k both fit 0..256
    localparam int DEN_W = 9;

    // v * k is at most one * 256
    localparam int PROD_W = FRAC_BITS + 9;

    // dimmed value quotient, one bit per divider stage
    localparam int QUO_W = FRAC_W;

    // divider remainder stays below the denominator
    localparam int REM_W = PROD_W - QUO_W;

    // chroma times sector factor (0..60) stays below one * 64
    localparam int XP_W = FRAC_BITS + 6;

    // reciprocal of 60, rounded up, exact for every product below 2^XP_W
    localparam int RCP_SH = XP_W + 6;
    localparam int RCP_W = RCP_SH - 5;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_SH) + 64'd59) / 64'd60);
    localparam int XQ_W = XP_W + RCP_W;

    // hue sectors, named by the order of the two nonzero channels
    localparam logic [2:0] SEC_R_G = 3'd0;
    localparam logic [2:0] SEC_G_R = 3'd1;
    localparam logic [2:0] SEC_G_B = 3'd2;
    localparam logic [2:0] SEC_B_G = 3'd3;
    localparam logic [2:0] SEC_B_R = 3'd4;
    localparam logic [2:0] SEC_R_B = 3'd5;

    // percent to fraction, percent above 100 saturates
    typedef frac_t pct_tbl_t [0:127];

    function automatic pct_tbl_t build_pct_tbl();
        pct_tbl_t tbl;
        longint unsigned pct;
        for (int i = 0; i < 128; i++)
        begin
            pct = (i > 100) ? 64'd100 : longint'(i);
            tbl[i] = FRAC_W'((pct << FRAC_BITS) / 64'd100);
        end
        return tbl;
    endfunction

    localparam pct_tbl_t PCT_TBL = build_pct_tbl();

    // per item data that rides along the divider
    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] factor;
        frac_t      sat;
    } side_t;

    // front end to divider
    typedef struct packed {
        logic              valid;
        logic [PROD_W-1:0] prod;
        side_t             side;
    } dim_req_t;

    // divider to colour stages
    typedef struct packed {
        logic  valid;
        frac_t vd;
        side_t side;
    } dim_rsp_t;

endpackage

// ===== src/hsv_front.sv =====
// ----------------------------------------------------------------------------
// hsv_front
// Input stage: hue sector and ramp factor, percent tables, distance numerator,
// then the product of value and numerator.
// ----------------------------------------------------------------------------
module hsv_front
    import hsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [8:0]       hue,
    input  logic [6:0]       saturation,
    input  logic [6:0]       brightness,
    input  logic [7:0]       distance,
    input  logic [DEN_W-1:0] den,
    output dim_req_t         req
);

    logic [8:0]        hue_w;
    logic [8:0]        base;
    logic [6:0]        t;
    logic [5:0]        d;
    logic [2:0]        sector_next;
    logic [5:0]        factor_next;
    logic [DEN_W-1:0]  k_next;
    logic [DEN_W-1:0]  dist_ext;

    logic              s0_valid_reg;
    logic [2:0]        s0_sector_reg;
    logic [5:0]        s0_factor_reg;
    frac_t             s0_sat_reg;
    frac_t             s0_val_reg;
    logic [DEN_W-1:0]  s0_k_reg;

    logic [PROD_W+DEN_W-1:0] prod_full;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    side_t             s1_side_reg;

    always_comb
    begin
        // one wrap brings any 9-bit hue below 360
        hue_w = (hue >= 9'd360) ? hue - 9'd360 : hue;

        if (hue_w inside {[9'd0:9'd59]})
            sector_next = SEC_R_G;
        else if (hue_w inside {[9'd60:9'd119]})
            sector_next = SEC_G_R;
        else if (hue_w inside {[9'd120:9'd179]})
            sector_next = SEC_G_B;
        else if (hue_w inside {[9'd180:9'd239]})
            sector_next = SEC_B_G;
        else if (hue_w inside {[9'd240:9'd299]})
            sector_next = SEC_B_R;
        else
            sector_next = SEC_R_B;

        if (hue_w < 9'd120)
            base = 9'd0;
        else if (hue_w < 9'd240)
            base = 9'd120;
        else
            base = 9'd240;

        t = 7'(hue_w - base);
        d = (t >= 7'd60) ? 6'(t - 7'd60) : 6'(7'd60 - t);
        factor_next = 6'd60 - d;

        dist_ext = {1'b0, distance};
        k_next = (dist_ext <= den) ? den - dist_ext : '0;
    end

    assign prod_full = s0_val_reg * s0_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_sector_reg      <= sector_next;
        s0_factor_reg      <= factor_next;
        s0_sat_reg         <= PCT_TBL[saturation];
        s0_val_reg         <= PCT_TBL[brightness];
        s0_k_reg           <= k_next;
        s1_prod_reg        <= prod_full[PROD_W-1:0];
        s1_side_reg.sector <= s0_sector_reg;
        s1_side_reg.factor <= s0_factor_reg;
        s1_side_reg.sat    <= s0_sat_reg;
    end

    assign req.valid = s1_valid_reg;
    assign req.prod  = s1_prod_reg;
    assign req.side  = s1_side_reg;

endmodule

// ===== src/hsv_div.sv =====
// ----------------------------------------------------------------------------
// hsv_div
// Pipelined restoring divider for the distance dimming, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module hsv_div
    import hsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DEN_W-1:0] den,
    input  dim_req_t         req,
    output dim_rsp_t         rsp
);

    logic             valid_reg [0:QUO_W-1];
    logic [REM_W-1:0] rem_reg   [0:QUO_W-1];
    logic [QUO_W-1:0] work_reg  [0:QUO_W-1];
    side_t            side_reg  [0:QUO_W-1];

    genvar i;
    generate
        for (i = 0; i < QUO_W; i++)
        begin : g_stage
            logic             src_valid;
            logic [REM_W-1:0] src_rem;
            logic [QUO_W-1:0] src_work;
            side_t            src_side;
            logic [REM_W:0]   trial;
            logic             ge;
            logic [REM_W-1:0] rem_next;
            logic [QUO_W-1:0] work_next;

            if (i == 0)
            begin : g_first
                assign src_valid = req.valid;
                assign src_rem   = req.prod[PROD_W-1:QUO_W];
                assign src_work  = req.prod[QUO_W-1:0];
                assign src_side  = req.side;
            end
            else
            begin : g_rest
                assign src_valid = valid_reg[i-1];
                assign src_rem   = rem_reg[i-1];
                assign src_work  = work_reg[i-1];
                assign src_side  = side_reg[i-1];
            end

            // dividend bits shift out the top, quotient bits shift in below
            assign trial     = {src_rem, src_work[QUO_W-1]};
            assign ge        = (trial >= den);
            assign rem_next  = ge ? REM_W'(trial - den) : trial[REM_W-1:0];
            assign work_next = {src_work[QUO_W-2:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[i] <= 1'b0;
                else
                    valid_reg[i] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= rem_next;
                work_reg[i] <= work_next;
                side_reg[i] <= src_side;
            end
        end
    endgenerate

    assign rsp.valid = valid_reg[QUO_W-1];
    assign rsp.vd    = work_reg[QUO_W-1];
    assign rsp.side  = side_reg[QUO_W-1];

endmodule

// ===== src/hsv_color.sv =====
// ----------------------------------------------------------------------------
// hsv_color
// Chroma, second component and offset, channel scaling and rgb565 packing.
// ----------------------------------------------------------------------------
module hsv_color
    import hsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dim_rsp_t rsp,
    output logic     done,
    output logic [15:0] rgb565
);

    logic [2*FRAC_W-1:0]   sv_prod;
    logic [FRAC_W+5:0]     cx_prod;
    logic [XQ_W-1:0]       xq_prod;
    frac_t                 x;
    frac_t                 rf_next;
    frac_t                 gf_next;
    frac_t                 bf_next;
    logic [FRAC_BITS+8:0]  r_scaled;
    logic [FRAC_BITS+8:0]  g_scaled;
    logic [FRAC_BITS+8:0]  b_scaled;
    logic [7:0]            r_byte;
    logic [7:0]            g_byte;
    logic [7:0]            b_byte;

    // stage c1: chroma
    logic       c1_valid_reg;
    frac_t      c1_c_reg;
    frac_t      c1_vd_reg;
    logic [2:0] c1_sector_reg;
    logic [5:0] c1_factor_reg;

    // stage c2: chroma times ramp factor, offset
    logic            c2_valid_reg;
    logic [XP_W-1:0] c2_p_reg;
    frac_t           c2_c_reg;
    frac_t           c2_m_reg;
    logic [2:0]      c2_sector_reg;

    // stage c3: reciprocal multiply for the divide by 60
    logic            c3_valid_reg;
    logic [XQ_W-1:0] c3_q_reg;
    frac_t           c3_c_reg;
    frac_t           c3_m_reg;
    logic [2:0]      c3_sector_reg;

    // stage c4: channel fractions
    logic  c4_valid_reg;
    frac_t c4_r_reg;
    frac_t c4_g_reg;
    frac_t c4_b_reg;

    // stage c5: packed output
    logic        c5_valid_reg;
    logic [15:0] c5_rgb_reg;

    assign sv_prod = rsp.side.sat * rsp.vd;
    assign cx_prod = c1_c_reg * c1_factor_reg;
    assign xq_prod = c2_p_reg * RCP_M;
    assign x       = c3_q_reg[RCP_SH +: FRAC_W];

    always_comb
    begin
        case (c3_sector_reg)
            SEC_R_G:
            begin
                rf_next = c3_c_reg + c3_m_reg;
                gf_next = x + c3_m_reg;
                bf_next = c3_m_reg;
            end
            SEC_G_R:
            begin
                rf_next = x + c3_m_reg;
                gf_next = c3_c_reg + c3_m_reg;
                bf_next = c3_m_reg;
            end
            SEC_G_B:
            begin
                rf_next = c3_m_reg;
                gf_next = c3_c_reg + c3_m_reg;
                bf_next = x + c3_m_reg;
            end
            SEC_B_G:
            begin
                rf_next = c3_m_reg;
                gf_next = x + c3_m_reg;
                bf_next = c3_c_reg + c3_m_reg;
            end
            SEC_B_R:
            begin
                rf_next = x + c3_m_reg;
                gf_next = c3_m_reg;
                bf_next = c3_c_reg + c3_m_reg;
            end
            SEC_R_B:
            begin
                rf_next = c3_c_reg + c3_m_reg;
                gf_next = c3_m_reg;
                bf_next = x + c3_m_reg;
            end
            default:
            begin
                rf_next = c3_m_reg;
                gf_next = c3_m_reg;
                bf_next = c3_m_reg;
            end
        endcase
    end

    // times 255 as shift and subtract, fraction of one gives exactly 255
    assign r_scaled = {c4_r_reg, 8'b0} - {8'b0, c4_r_reg};
    assign g_scaled = {c4_g_reg, 8'b0} - {8'b0, c4_g_reg};
    assign b_scaled = {c4_b_reg, 8'b0} - {8'b0, c4_b_reg};
    assign r_byte   = r_scaled[FRAC_BITS+7:FRAC_BITS];
    assign g_byte   = g_scaled[FRAC_BITS+7:FRAC_BITS];
    assign b_byte   = b_scaled[FRAC_BITS+7:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
            c3_valid_reg <= 1'b0;
            c4_valid_reg <= 1'b0;
            c5_valid_reg <= 1'b0;
        end
        else
        begin
            c1_valid_reg <= rsp.valid;
            c2_valid_reg <= c1_valid_reg;
            c3_valid_reg <= c2_valid_reg;
            c4_valid_reg <= c3_valid_reg;
            c5_valid_reg <= c4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c1_c_reg      <= sv_prod[FRAC_BITS +: FRAC_W];
        c1_vd_reg     <= rsp.vd;
        c1_sector_reg <= rsp.side.sector;
        c1_factor_reg <= rsp.side.factor;

        c2_p_reg      <= cx_prod[XP_W-1:0];
        c2_c_reg      <= c1_c_reg;
        c2_m_reg      <= c1_vd_reg - c1_c_reg;
        c2_sector_reg <= c1_sector_reg;

        c3_q_reg      <= xq_prod;
        c3_c_reg      <= c2_c_reg;
        c3_m_reg      <= c2_m_reg;
        c3_sector_reg <= c2_sector_reg;

        c4_r_reg      <= rf_next;
        c4_g_reg      <= gf_next;
        c4_b_reg      <= bf_next;

        c5_rgb_reg    <= {r_byte[7:3], g_byte[7:2], b_byte[7:3]};
    end

    assign done   = c5_valid_reg;
    assign rgb565 = c5_rgb_reg;

endmodule

// ===== src/hsv_to_rgb565_dimmed.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb565_dimmed
// Hsv to rgb565 colour conversion with linear distance dimming.
// ----------------------------------------------------------------------------
// A fully pipelined converter: one transaction may start on every clock and
// busy never rises. Each result appears on rgb565 with done high for exactly
// one cycle; the receiver cannot stall it, so it must take every result as it
// comes. The pipeline holds the dimming divider (17 stages, one quotient bit
// each), plus 2 front stages and 5 colour stages. ray_length is written over
// the cfg channel, which is always ready; write it only while no transaction
// is in flight.
module hsv_to_rgb565_dimmed
    import hsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [8:0]  hue,
    input  logic [6:0]  saturation,
    input  logic [6:0]  brightness,
    input  logic [7:0]  distance,
    output logic        done,
    output logic [15:0] rgb565,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]       ray_length_reg;
    logic [DEN_W-1:0] den;
    logic             in_valid;
    dim_req_t         req;
    dim_rsp_t         rsp;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start & ~busy;
    assign den       = {1'b0, ray_length_reg} + DEN_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ray_length_reg <= 8'd16;
        else if (cfg_valid && cfg_ready)
            ray_length_reg <= cfg_data;
    end

    hsv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .distance   (distance),
        .den        (den),
        .req        (req)
    );

    hsv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .den   (den),
        .req   (req),
        .rsp   (rsp)
    );

    hsv_color u_color (
        .clk    (clk),
        .rst_n  (rst_n),
        .rsp    (rsp),
        .done   (done),
        .rgb565 (rgb565)
    );

endmodule

// ===== tb/tb_hsv_to_rgb565_dimmed.sv =====
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb565_dimmed
// Self-checking bench for the dimmed hsv to rgb565 converter: a queue-fed
// driver issues colors with random spacing and a monitor checks every packed
// result against a fixed point color predictor, over several ray lengths.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb565_dimmed;
    import hsv_pkg::*;

    localparam int SETTLE_CYCLES = 32;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 244;
    localparam int CHUNK_ITEMS   = 40;

    typedef struct {
        logic [8:0]  hue;
        logic [6:0]  sat;
        logic [6:0]  bri;
        logic [7:0]  dst;
        int unsigned gap;
        bit          drain;
    } color_req_t;

    typedef struct {
        logic [8:0]  hue;
        logic [6:0]  sat;
        logic [6:0]  bri;
        logic [7:0]  dst;
        logic [7:0]  len;
        logic [15:0] rgb;
    } rgb_expect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [8:0]  hue = '0;
    logic [6:0]  saturation = '0;
    logic [6:0]  brightness = '0;
    logic [7:0]  distance = '0;
    logic        done;
    logic [15:0] rgb565;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    color_req_t  color_req_q [$];
    rgb_expect_t rgb_expect_q [$];
    color_req_t  cur_req;
    bit          have_cur = 1'b0;
    bit          cur_launched = 1'b0;
    bit          launch_taken = 1'b0;
    int unsigned gap_left = 0;

    logic [7:0]  ray_len_model = 8'd16;
    int unsigned pushed_total = 0;
    int unsigned colors_sent = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    hsv_to_rgb565_dimmed uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .distance   (distance),
        .done       (done),
        .rgb565     (rgb565),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [7:0] to_channel(input longint unsigned frac);
        longint unsigned scaled;
        scaled = (frac * 255) >> FRAC_BITS;
        return (scaled > 255) ? 8'hFF : scaled[7:0];
    endfunction

    function automatic logic [15:0] predict_rgb565(input logic [8:0] h_in,
                                                   input logic [6:0] s_in,
                                                   input logic [6:0] b_in,
                                                   input logic [7:0] d_in,
                                                   input logic [7:0] len);
        longint unsigned one, h, sp, bp, den, k, s, v, vd, c, x, m, t, dev;
        longint unsigned r, g, b;
        logic [2:0]      sec;
        logic [7:0]      r8, g8, b8;
        one = 64'd1 << FRAC_BITS;
        h = h_in;
        if (h >= 360)
            h = h - 360;
        sp = (s_in > 7'd100) ? 100 : s_in;
        bp = (b_in > 7'd100) ? 100 : b_in;
        s = (sp * one) / 100;
        v = (bp * one) / 100;
        den = longint'(len) + 1;
        k = (d_in <= den) ? den - d_in : 0;
        vd = (v * k) / den;
        c = (s * vd) >> FRAC_BITS;
        t = h % 120;
        dev = (t >= 60) ? t - 60 : 60 - t;
        x = (c * (60 - dev)) / 60;
        m = vd - c;
        sec = 3'(h / 60);
        case (sec)
            SEC_R_G: begin r = c; g = x; b = 0; end
            SEC_G_R: begin r = x; g = c; b = 0; end
            SEC_G_B: begin r = 0; g = c; b = x; end
            SEC_B_G: begin r = 0; g = x; b = c; end
            SEC_B_R: begin r = x; g = 0; b = c; end
            default: begin r = c; g = 0; b = x; end
        endcase
        r8 = to_channel(r + m);
        g8 = to_channel(g + m);
        b8 = to_channel(b + m);
        return {r8[7:3], g8[7:2], b8[7:3]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic queue_color(input logic [8:0] h, input logic [6:0] s,
                               input logic [6:0] b, input logic [7:0] d,
                               input int unsigned gap, input bit drain);
        color_req_t req;
        req.hue = h;
        req.sat = s;
        req.bri = b;
        req.dst = d;
        req.gap = gap;
        req.drain = drain;
        color_req_q.push_back(req);
        pushed_total++;
    endtask

    function automatic logic [6:0] pick_percent();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 7'($urandom_range(101, 127));
        else if (roll == 1)
            return ($urandom_range(0, 1) == 0) ? 7'd0 : 7'd100;
        return 7'($urandom_range(0, 100));
    endfunction

    task automatic queue_random(input logic [7:0] len, input int unsigned mode);
        logic [8:0]  h;
        logic [7:0]  d;
        int unsigned gap;
        int unsigned dmax;
        h = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                        : 9'($urandom_range(0, 359));
        dmax = (int'(len) + 2 > 255) ? 255 : int'(len) + 2;
        d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, dmax));
        case (mode)
            0: gap = 0;
            1: gap = $urandom_range(0, 18);
            default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        endcase
        queue_color(h, pick_percent(), pick_percent(), d, gap,
                    $urandom_range(0, 99) == 0);
    endtask

    task automatic write_ray_length(input logic [7:0] val);
        int unsigned seen;
        seen = cfg_writes;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        wait (cfg_writes != seen);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (results_seen == pushed_total);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // driver: one request held on the ports until the block takes it
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (launch_taken)
            begin
                launch_taken = 1'b0;
                have_cur = 1'b0;
                cur_launched = 1'b0;
            end
            if (!have_cur && color_req_q.size() > 0)
            begin
                cur_req = color_req_q.pop_front();
                have_cur = 1'b1;
                gap_left = cur_req.gap;
            end
            if (have_cur && gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (have_cur &&
                     (cur_launched || !cur_req.drain || rgb_expect_q.size() == 0))
            begin
                cur_launched = 1'b1;
                start <= 1'b1;
                hue <= cur_req.hue;
                saturation <= cur_req.sat;
                brightness <= cur_req.bri;
                distance <= cur_req.dst;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: predicts on each accepted transaction, checks each strobe
    always @(posedge clk)
    begin
        rgb_expect_t got_exp;
        rgb_expect_t new_exp;
        bit          activity;
        if (rst_n)
        begin
            activity = 1'b0;
            if (done)
            begin
                activity = 1'b1;
                results_seen++;
                if (rgb_expect_q.size() == 0)
                    report_mismatch($sformatf("rgb565 %h with no conversion pending",
                                              rgb565));
                else
                begin
                    got_exp = rgb_expect_q.pop_front();
                    if (rgb565 !== got_exp.rgb)
                        report_mismatch($sformatf(
                            "hue %0d sat %0d bri %0d dist %0d len %0d: rgb565 %h, want %h",
                            got_exp.hue, got_exp.sat, got_exp.bri, got_exp.dst,
                            got_exp.len, rgb565, got_exp.rgb));
                end
            end
            if (start && !busy)
            begin
                activity = 1'b1;
                new_exp.hue = hue;
                new_exp.sat = saturation;
                new_exp.bri = brightness;
                new_exp.dst = distance;
                new_exp.len = ray_len_model;
                new_exp.rgb = predict_rgb565(hue, saturation, brightness, distance,
                                             ray_len_model);
                rgb_expect_q.push_back(new_exp);
                launch_taken = 1'b1;
                colors_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                activity = 1'b1;
                ray_len_model = cfg_data;
                cfg_writes++;
            end
            idle_cycles = activity ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d outstanding",
                         $realtime, IDLE_LIMIT, rgb_expect_q.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0]  lengths [8];
        int unsigned mode;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // reset ray length 16: sector edges, hue wrap, percent clamp, dimming edges
        queue_color(9'd0,   7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd59,  7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd60,  7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd119, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd120, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd179, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd180, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd239, 7'd100, 7'd100, 8'd0,   3, 1'b0);
        queue_color(9'd240, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd299, 7'd100, 7'd100, 8'd0,   1, 1'b0);
        queue_color(9'd300, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd359, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd360, 7'd100, 7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd511, 7'd127, 7'd127, 8'd0,   18, 1'b0);
        queue_color(9'd400, 7'd60,  7'd80,  8'd3,   0, 1'b0);
        queue_color(9'd30,  7'd0,   7'd100, 8'd0,   0, 1'b0);
        queue_color(9'd200, 7'd100, 7'd0,   8'd0,   0, 1'b0);
        queue_color(9'd90,  7'd0,   7'd0,   8'd255, 0, 1'b0);
        queue_color(9'd45,  7'd50,  7'd73,  8'd5,   0, 1'b0);
        queue_color(9'd150, 7'd100, 7'd100, 8'd16,  0, 1'b1);
        queue_color(9'd150, 7'd100, 7'd100, 8'd17,  0, 1'b0);
        queue_color(9'd150, 7'd100, 7'd100, 8'd18,  0, 1'b0);
        queue_color(9'd270, 7'd127, 7'd101, 8'd255, 0, 1'b0);
        wait_drained();

        lengths = '{8'd255, 8'd0, 8'd1, 8'd200, 8'd7,
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd16};
        foreach (lengths[p])
        begin
            write_ray_length(lengths[p]);
            mode = 0;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // per chunk, pick back-to-back bursts, sparse stretches or a mix at random
                if (i % CHUNK_ITEMS == 0)
                    mode = $urandom_range(0, 2);
                queue_random(lengths[p], mode);
            end
            wait_drained();
        end

        if (rgb_expect_q.size() != 0)
            report_mismatch($sformatf("%0d conversions never produced a result",
                                      rgb_expect_q.size()));
        $display("covered %0d conversions and %0d results across %0d ray length writes",
                 colors_sent, results_seen, cfg_writes);
        $display("ray lengths 0 to 255, all sectors, hue wrap, percent clamp, full dimming");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
